// ===== rtl/rru_pkg.sv =====
`default_nettype none
package rru_pkg;
   localparam int IN_W    = 16;
   localparam int OUT_W   = 18;
   localparam int OUT_MAX = 131071;
   localparam int OUT_MIN = -131072;
   localparam int DOT_W   = 34;   // sum of three 16x16 signed products

   localparam logic ACT_REFLECT = 1'b0;
   localparam logic ACT_REFRACT = 1'b1;
endpackage
`default_nettype wire

// ===== rtl/ray_reflect_refract_unit.sv =====
`default_nettype none
// Channel  Dir  tdata (low bit first)                               tuser
// req_     in   dir_x, dir_y, dir_z, norm_x, norm_y, norm_z,        action
//               index_ratio (112 bits)
// rsp_     out  out_x, out_y, out_z (54 bits, zero fill to 56)      total_reflection
//
// One word accepted per cycle while the output register is empty or being taken;
// the pipeline length is set by the square root, which resolves one root bit per pipeline stage.
// Reset clears the stage valid bits only.
// The whole pipeline advances together whenever the output register is empty
// or being taken, so a stall freezes every stage in place.
module ray_reflect_refract_unit
   import rru_pkg::*;
#(
   parameter int FRAC_BITS = 14
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [111:0] req_tdata,  // dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, index_ratio
   input  wire logic         req_tuser,  // action
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [55:0]       rsp_tdata,  // out_x, out_y, out_z, zero fill
   output logic              rsp_tuser   // total_reflection
);
   localparam int F    = FRAC_BITS;
   localparam int CW   = DOT_W + 1 - F;
   localparam int CCW  = 2 * CW;
   localparam int SW   = CCW + 1 - F;
   localparam int TW   = (SW + 1 > F + 2) ? SW + 1 : F + 2;
   localparam int R2W  = 33 - F;
   localparam int KW0  = R2W + TW + 2;
   localparam int KW   = (KW0 > 2 * F + 2) ? KW0 : 2 * F + 2;
   localparam int QW   = KW / 2;
   localparam int UW   = 2 * QW;
   localparam int RCW  = CW + 17;
   localparam int QFW  = QW + F + 1;
   localparam int MW0  = ((RCW > QFW) ? RCW : QFW) + 1;
   localparam int MW   = (MW0 > DOT_W + 2) ? MW0 : DOT_W + 2;
   localparam int AW   = ((IN_W + 2 * F > 33 + F) ? IN_W + 2 * F : 33 + F) + 1;
   localparam int MNW  = MW + IN_W;
   localparam int EW   = ((MNW > AW) ? MNW : AW) + 1;
   localparam int RW   = EW - 2 * F;

   typedef struct packed {
      logic                   act;
      logic [2:0][IN_W-1:0]   n;
      logic [2:0][AW-1:0]     a;
      logic [DOT_W-1:0]       dot;
      logic [RCW-1:0]         rc;
   } carry_type;

   typedef struct packed {
      logic [QW+1:0] rem;
      logic [QW-1:0] root;
      logic [UW-1:0] op;
      logic          tir;
   } sq_type;

   logic en;
   assign en         = ~rsp_tvalid | rsp_tready;
   assign req_tready = en;

   // stage 1: input register
   logic                   v1_ff;
   logic                   act1_ff;
   logic signed [IN_W-1:0] d1_ff [3];
   logic signed [IN_W-1:0] n1_ff [3];
   logic [IN_W-1:0]        r1_ff;

   // stage 2: products
   logic                   v2_ff, act2_ff;
   logic signed [IN_W-1:0] n2_ff [3];
   logic signed [IN_W-1:0] d2_ff [3];
   logic signed [31:0]     p2_ff [3];
   logic signed [32:0]     rd2_ff [3];
   logic [31:0]            rr2_ff;
   logic [IN_W-1:0]        r2r_ff;

   // stage 3: dot product, r squared, scaled direction
   logic                    v3_ff, act3_ff;
   logic signed [IN_W-1:0]  n3_ff [3];
   logic signed [AW-1:0]    a3_ff [3];
   logic signed [DOT_W-1:0] dot3_ff;
   logic [R2W-1:0]          rsq3_ff;
   logic [IN_W-1:0]         r3_ff;

   // stage 4: c squared and r*c
   logic                    v4_ff;
   carry_type               car4_ff;
   logic signed [CCW-1:0]   cc4_ff;
   logic [R2W-1:0]          rsq4_ff;

   // stage 5: t = 1 - c^2
   logic                    v5_ff;
   carry_type               car5_ff;
   logic signed [TW-1:0]    t5_ff;
   logic [R2W-1:0]          rsq5_ff;

   // stage 6 onwards: square root, one bit per stage
   logic                    sv_ff  [QW+1];
   sq_type                  sq_ff  [QW+1];
   carry_type               scar_ff[QW+1];

   // stage 7: multiplier operand select
   logic                    v7_ff, tir7_ff;
   logic signed [MW-1:0]    m7_ff;
   logic [2:0][IN_W-1:0]    n7_ff;
   logic [2:0][AW-1:0]      a7_ff;

   // stage 8: m * n
   logic                    v8_ff, tir8_ff;
   logic signed [MNW-1:0]   mn8_ff [3];
   logic [2:0][AW-1:0]      a8_ff;

   // output register
   logic                    vo_ff, tiro_ff;
   logic [OUT_W-1:0]        out_ff [3];

   // combinational values per stage
   logic signed [DOT_W:0]     csum4;
   logic signed [CW-1:0]      c4;
   logic [CCW:0]              ccsum5;
   logic [SW-1:0]             s5;
   logic signed [R2W+TW:0]    prod6;
   logic signed [KW-1:0]      k6;
   logic [32:0]               rrsum3;
   logic signed [MW-1:0]      m7_in;
   logic [OUT_W-1:0]          out_in [3];

   always_comb begin
      rrsum3 = {1'b0, rr2_ff} + (33'(1) << (F - 1));
      csum4  = (DOT_W + 1)'(dot3_ff) + $signed((DOT_W + 1)'(1) << (F - 1));
      c4     = csum4[DOT_W:F];
      ccsum5 = {1'b0, cc4_ff} + ((CCW + 1)'(1) << (F - 1));
      s5     = ccsum5[CCW:F];
      prod6  = $signed({1'b0, rsq5_ff}) * t5_ff;
      k6     = $signed(KW'(1) << (2 * F)) - KW'(prod6);
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0; v5_ff <= 1'b0;
         v7_ff <= 1'b0; v8_ff <= 1'b0; vo_ff <= 1'b0;
         for (int j = 0; j <= QW; j++) sv_ff[j] <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         sv_ff[0] <= v5_ff;
         for (int j = 0; j < QW; j++) sv_ff[j+1] <= sv_ff[j];
         v7_ff <= sv_ff[QW];
         v8_ff <= v7_ff;
         vo_ff <= v8_ff;
      end
   end

   // front stages
   always_ff @(posedge clock) begin
      if (en) begin
         act1_ff <= req_tuser;
         for (int i = 0; i < 3; i++) begin
            d1_ff[i] <= req_tdata[16*i +: 16];
            n1_ff[i] <= req_tdata[48 + 16*i +: 16];
         end
         r1_ff <= req_tdata[111:96];

         act2_ff <= act1_ff;
         r2r_ff  <= r1_ff;
         rr2_ff  <= r1_ff * r1_ff;
         for (int i = 0; i < 3; i++) begin
            n2_ff[i]  <= n1_ff[i];
            d2_ff[i]  <= d1_ff[i];
            p2_ff[i]  <= n1_ff[i] * d1_ff[i];
            rd2_ff[i] <= $signed({1'b0, r1_ff}) * d1_ff[i];
         end

         act3_ff <= act2_ff;
         r3_ff   <= r2r_ff;
         rsq3_ff <= rrsum3[32:F];
         dot3_ff <= DOT_W'(p2_ff[0]) + DOT_W'(p2_ff[1]) + DOT_W'(p2_ff[2]);
         for (int i = 0; i < 3; i++) begin
            n3_ff[i] <= n2_ff[i];
            a3_ff[i] <= (act2_ff == ACT_REFRACT) ? (AW'(rd2_ff[i]) <<< F)
                                                  : (AW'(d2_ff[i]) <<< (2 * F));
         end

         car4_ff.act <= act3_ff;
         car4_ff.dot <= dot3_ff;
         car4_ff.rc  <= RCW'($signed({1'b0, r3_ff}) * c4);
         for (int i = 0; i < 3; i++) begin
            car4_ff.n[i] <= n3_ff[i];
            car4_ff.a[i] <= a3_ff[i];
         end
         cc4_ff  <= c4 * c4;
         rsq4_ff <= rsq3_ff;

         car5_ff <= car4_ff;
         rsq5_ff <= rsq4_ff;
         t5_ff   <= $signed(TW'(1) << F) - $signed(TW'(s5));

         // stage 6: k and negative-k flag, seeds the root
         scar_ff[0]     <= car5_ff;
         sq_ff[0].rem   <= '0;
         sq_ff[0].root  <= '0;
         sq_ff[0].op    <= k6[KW-1] ? '0 : UW'(k6);
         sq_ff[0].tir   <= (car5_ff.act == ACT_REFRACT) && k6[KW-1];
      end
   end

   // digit-by-digit square root
   for (genvar j = 0; j < QW; j++) begin : g_sqrt
      logic [QW+1:0] remn, trial;
      sq_type        nxt;
      always_comb begin
         remn  = {sq_ff[j].rem[QW-1:0], sq_ff[j].op[UW-1:UW-2]};
         trial = {sq_ff[j].root, 2'b01};
         nxt.op  = sq_ff[j].op << 2;
         nxt.tir = sq_ff[j].tir;
         if (remn >= trial) begin
            nxt.rem  = remn - trial;
            nxt.root = {sq_ff[j].root[QW-2:0], 1'b1};
         end else begin
            nxt.rem  = remn;
            nxt.root = {sq_ff[j].root[QW-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            sq_ff[j+1]   <= nxt;
            scar_ff[j+1] <= scar_ff[j];
         end
      end
   end

   // reflect scales n by 2(n.d); refract by r*c + q
   always_comb begin
      if (scar_ff[QW].act == ACT_REFRACT)
         m7_in = MW'($signed(scar_ff[QW].rc))
               + $signed(MW'({1'b0, sq_ff[QW].root}) << F);
      else
         m7_in = MW'($signed(scar_ff[QW].dot)) <<< 1;
   end

   // rounding and saturation; all-zero output on total reflection
   always_comb begin
      logic signed [EW-1:0] diff;
      logic signed [EW-1:0] rs;
      logic signed [RW-1:0] rnd;
      for (int i = 0; i < 3; i++) begin
         diff = EW'($signed(a8_ff[i])) - EW'(mn8_ff[i]);
         rs   = diff + $signed(EW'(1) << (2 * F - 1));
         rnd  = rs[EW-1:2*F];
         if (tir8_ff)
            out_in[i] = '0;
         else if (rnd > $signed(RW'(OUT_MAX)))
            out_in[i] = OUT_W'(OUT_MAX);
         else if (rnd < $signed(RW'(OUT_MIN)))
            out_in[i] = OUT_W'(OUT_MIN);
         else
            out_in[i] = rnd[OUT_W-1:0];
      end
   end

   // back stages
   always_ff @(posedge clock) begin
      if (en) begin
         tir7_ff <= sq_ff[QW].tir;
         m7_ff   <= m7_in;
         n7_ff   <= scar_ff[QW].n;
         a7_ff   <= scar_ff[QW].a;

         tir8_ff <= tir7_ff;
         a8_ff   <= a7_ff;
         for (int i = 0; i < 3; i++)
            mn8_ff[i] <= m7_ff * $signed(n7_ff[i]);

         tiro_ff <= tir8_ff;
         for (int i = 0; i < 3; i++) out_ff[i] <= out_in[i];
      end
   end

   assign rsp_tvalid = vo_ff;
   assign rsp_tuser  = tiro_ff;
   assign rsp_tdata  = {2'b00, out_ff[2], out_ff[1], out_ff[0]};
endmodule
`default_nettype wire
